### rtl/core/rtctbl_pkg.sv
// Shared types and constants for the range threshold color table.
// Used by the table cells, the result stage and the top level.
package rtctbl_pkg;

    localparam int KEY_W     = 64;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 8;
    localparam int IN_DATA_W = 112;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    localparam logic [COLOR_W-1:0] DEFAULT_BG_RESET = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] DEFAULT_FG_RESET = 24'h000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_BG = 8'd0,
        CFG_DEFAULT_FG = 8'd1
    } cfg_index_t;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] minimum;
        logic [COLOR_W-1:0]      bg;
        logic [COLOR_W-1:0]      fg;
    } entry_t;

    // Compare status a cell shows its neighbors.
    typedef struct packed {
        logic valid;
        logic ge;
        logic eq;
        logic lt;
    } cell_stat_t;

    // Virtual neighbor in front of the first cell: valid and below every key.
    localparam cell_stat_t CELL_HEAD = '{valid: 1'b1, ge: 1'b0, eq: 1'b0, lt: 1'b1};
    // Virtual neighbor behind the last cell: never valid.
    localparam cell_stat_t CELL_TAIL = '{valid: 1'b0, ge: 1'b0, eq: 1'b0, lt: 1'b0};

endpackage

### rtl/core/range_threshold_color_table_core.sv
// Top level of the range threshold color table: a chain of sorted entry
// cells, a select register and the result stage. Depends on rtctbl_pkg,
// rtctbl_cell and rtctbl_result.
//
//   Group   Dir  Signals                          Payload
//   s_*     in   s_tvalid s_tready s_tdata s_tuser key, entry_bg_color, entry_fg_color; op
//   m_*     out  m_tvalid m_tready m_tdata m_tuser bg_color, fg_color; matched, table_full
//   cfg_*   in   cfg_valid cfg_ready cfg_index cfg_data  default color registers
//
// When a word is accepted, every cell compares the key at once, and an
// insert shifts the cells behind the insert point by one place at that edge.
// Its result passes the select register, then the result stage register;
// one word per cycle is sustained while the output side keeps taking words.
// Reset empties the table and restores the default colors; no sweep is needed.
// A stalled output holds its word; input stalls only once both stages are full.
module range_threshold_color_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // key[63:0], entry_bg_color[87:64], entry_fg_color[111:88]
    input  logic [0:0]    s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // bg_color[23:0], fg_color[47:24]
    output logic [1:0]    m_tuser,   // matched[0], table_full[1]
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [23:0]   cfg_data
);
    import rtctbl_pkg::*;

    logic [COLOR_W-1:0] default_bg_reg;
    logic [COLOR_W-1:0] default_fg_reg;

    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic               s1_full_reg;
    logic [ENTRIES-1:0] s1_sel_reg;
    logic               s1_ready;

    logic signed [KEY_W-1:0] key;
    entry_t             new_entry;
    logic               accept;
    logic               full;
    logic               ins_en;

    cell_stat_t         stats   [ENTRIES];
    entry_t             entries [ENTRIES];
    logic [ENTRIES-1:0] sel;

    assign key       = s_tdata[63:0];
    assign new_entry = '{minimum: s_tdata[63:0], bg: s_tdata[87:64], fg: s_tdata[111:88]};
    assign s_tready  = !s1_valid_reg || s1_ready;
    assign accept    = s_tvalid && s_tready;
    assign full      = stats[ENTRIES-1].valid;
    assign ins_en    = accept && (s_tuser[0] == OP_INSERT) && !full;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        cell_stat_t prev_stat;
        cell_stat_t next_stat;
        entry_t     prev_entry;

        if (i == 0)
        begin : g_head
            assign prev_stat  = CELL_HEAD;
            assign prev_entry = new_entry;
        end
        else
        begin : g_body
            assign prev_stat  = stats[i-1];
            assign prev_entry = entries[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_tail
            assign next_stat = CELL_TAIL;
        end
        else
        begin : g_inner
            assign next_stat = stats[i+1];
        end

        rtctbl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .key        (key),
            .new_entry  (new_entry),
            .ins_en     (ins_en),
            .prev_stat  (prev_stat),
            .prev_entry (prev_entry),
            .next_stat  (next_stat),
            .stat       (stats[i]),
            .entry      (entries[i]),
            .sel        (sel[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= s_tuser[0];
            s1_full_reg <= full;
            s1_sel_reg  <= sel;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_bg_reg <= DEFAULT_BG_RESET;
            default_fg_reg <= DEFAULT_FG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_BG: default_bg_reg <= cfg_data;
                CFG_DEFAULT_FG: default_fg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rtctbl_result #(
        .ENTRIES (ENTRIES)
    ) u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_op      (s1_op_reg),
        .s1_full    (s1_full_reg),
        .s1_sel     (s1_sel_reg),
        .entries    (entries),
        .default_bg (default_bg_reg),
        .default_fg (default_fg_reg),
        .s1_ready   (s1_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### rtl/core/rtctbl_cell.sv
// One entry of the sorted table: holds a minimum and a color pair,
// compares it with the incoming key and shifts toward the tail on insert.
// Depends on rtctbl_pkg.
module rtctbl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [63:0]  key,
    input  rtctbl_pkg::entry_t  new_entry,
    input  logic                ins_en,
    input  rtctbl_pkg::cell_stat_t prev_stat,
    input  rtctbl_pkg::entry_t  prev_entry,
    input  rtctbl_pkg::cell_stat_t next_stat,
    output rtctbl_pkg::cell_stat_t stat,
    output rtctbl_pkg::entry_t  entry,
    output logic                sel
);
    import rtctbl_pkg::*;

    logic   valid_reg;
    entry_t entry_reg;
    logic   shift_in;
    logic   take_new;

    always_comb
    begin
        stat.valid = valid_reg;
        stat.ge    = valid_reg && !(entry_reg.minimum < key);
        stat.eq    = valid_reg && (entry_reg.minimum == key);
        stat.lt    = valid_reg && (entry_reg.minimum < key);
    end

    // The first exact match wins; otherwise the last entry below the key,
    // provided the entry behind it does not match exactly.
    assign sel = (stat.eq && !prev_stat.ge) ||
                 (stat.lt && !next_stat.lt && !next_stat.eq);

    // Cells at or behind the insert point move one place toward the tail.
    assign shift_in = prev_stat.ge;
    assign take_new = !prev_stat.ge && prev_stat.valid && (stat.ge || !valid_reg);

    assign entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ins_en && (shift_in || take_new))
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_en && shift_in)
        begin
            entry_reg <= prev_entry;
        end
        else if (ins_en && take_new)
        begin
            entry_reg <= new_entry;
        end
    end

endmodule

### rtl/core/rtctbl_result.sv
// Result stage: gathers the selected entry's colors or default pair
// (zero on an insert), holds the output word. Depends on rtctbl_pkg.
module rtctbl_result #(
    parameter int ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s1_valid,
    input  logic                      s1_op,
    input  logic                      s1_full,
    input  logic [ENTRIES-1:0]        s1_sel,
    input  rtctbl_pkg::entry_t        entries [ENTRIES],
    input  logic [23:0]               default_bg,
    input  logic [23:0]               default_fg,
    output logic                      s1_ready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,   // bg_color, fg_color
    output logic [1:0]                m_tuser    // matched, table_full
);
    import rtctbl_pkg::*;

    logic               m_valid_reg;
    logic [47:0]        m_data_reg;
    logic [1:0]         m_user_reg;
    logic [47:0]        data_next;
    logic [1:0]         user_next;
    logic [COLOR_W-1:0] hit_bg;
    logic [COLOR_W-1:0] hit_fg;
    logic               hit;

    // At most one cell is selected, so an AND-OR gathers its colors.
    always_comb
    begin
        hit_bg = '0;
        hit_fg = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_bg = hit_bg | (entries[i].bg & {COLOR_W{s1_sel[i]}});
            hit_fg = hit_fg | (entries[i].fg & {COLOR_W{s1_sel[i]}});
        end
        hit = |s1_sel;
    end

    always_comb
    begin
        if (s1_op == OP_INSERT)
        begin
            data_next = '0;
            user_next = {s1_full, 1'b0};
        end
        else if (hit)
        begin
            data_next = {hit_fg, hit_bg};
            user_next = 2'b01;
        end
        else
        begin
            data_next = {default_fg, default_bg};
            user_next = 2'b00;
        end
    end

    assign s1_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            m_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
        begin
            m_data_reg <= data_next;
            m_user_reg <= user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### bench/range_threshold_color_table_core_tb.sv
// Self-checking testbench for range_threshold_color_table_core: directed and random
// lookup and insert words, checked against a sorted-table predictor kept in the bench.
// Depends on rtctbl_pkg and the core RTL.
module range_threshold_color_table_core_tb;

    import rtctbl_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int LATENCY     = 4;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    // No register lives at this index, so a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd7;

    typedef struct {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic [COLOR_W-1:0]      bg;
        logic [COLOR_W-1:0]      fg;
    } table_word_t;

    typedef struct {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic               matched;
        logic               full;
    } color_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata = '0;   // key[63:0], entry_bg_color[87:64], entry_fg_color[111:88]
    logic [0:0]    s_tuser = '0;   // op
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [47:0]   m_tdata;        // bg_color[23:0], fg_color[47:24]
    logic [1:0]    m_tuser;        // matched[0], table_full[1]
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_index = '0;
    logic [23:0]   cfg_data = '0;

    // Predicted table contents and default colors.
    logic signed [KEY_W-1:0] tbl_min [ENTRIES];
    logic [COLOR_W-1:0]      tbl_bg [ENTRIES];
    logic [COLOR_W-1:0]      tbl_fg [ENTRIES];
    int                      tbl_count = 0;
    logic [COLOR_W-1:0]      dflt_bg = DEFAULT_BG_RESET;
    logic [COLOR_W-1:0]      dflt_fg = DEFAULT_FG_RESET;

    table_word_t   pending_words[$];
    color_result_t expected_colors[$];
    int            words_queued = 0;
    int            words_checked = 0;
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          hold_go = 1'b0;
    logic          hold_used = 1'b0;
    int            hold_left = 0;

    range_threshold_color_table_core #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Applies one accepted word to the predicted table and returns its result.
    function automatic color_result_t apply_table_word(op_t op, logic signed [KEY_W-1:0] key,
                                                       logic [COLOR_W-1:0] bg,
                                                       logic [COLOR_W-1:0] fg);
        color_result_t r;
        int            pos;
        int            j;
        r = '{bg: '0, fg: '0, matched: 1'b0, full: 1'b0};
        pos = 0;
        while (pos < tbl_count && tbl_min[pos] < key)
            pos++;
        if (op == OP_INSERT)
        begin
            if (tbl_count >= ENTRIES)
            begin
                r.full = 1'b1;
            end
            else
            begin
                for (j = tbl_count; j > pos; j--)
                begin
                    tbl_min[j] = tbl_min[j-1];
                    tbl_bg[j]  = tbl_bg[j-1];
                    tbl_fg[j]  = tbl_fg[j-1];
                end
                tbl_min[pos] = key;
                tbl_bg[pos]  = bg;
                tbl_fg[pos]  = fg;
                tbl_count++;
            end
            return r;
        end
        // An exact hit takes the newest entry of that minimum; otherwise the
        // entry just below the insert point, which is the oldest of its minimum.
        if (!(pos < tbl_count && tbl_min[pos] == key))
        begin
            if (pos == 0)
            begin
                r.bg = dflt_bg;
                r.fg = dflt_fg;
                return r;
            end
            pos--;
        end
        r.bg = tbl_bg[pos];
        r.fg = tbl_fg[pos];
        r.matched = 1'b1;
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(bit for_insert);
        logic signed [KEY_W-1:0] k;
        int                      sel;
        int                      idx;
        sel = $urandom_range(7);
        k = {$urandom, $urandom};
        idx = (tbl_count > 0) ? $urandom_range(tbl_count - 1) : 0;
        if (for_insert)
        begin
            // Mostly a narrow band so that equal minimums pile up.
            if (sel < 6)
                k = KEY_W'(int'($urandom_range(2000)) - 1000);
        end
        else
        begin
            case (sel)
                2, 3: if (tbl_count > 0) k = tbl_min[idx];
                4:    if (tbl_count > 0) k = tbl_min[idx] + ($urandom_range(1) ? 64'sd1 : -64'sd1);
                5:    k = KEY_W'(int'($urandom_range(2000)) - 1000);
                6:    k = KEY_MIN;
                7:    k = KEY_MAX;
                default: ;
            endcase
        end
        return k;
    endfunction

    task automatic queue_word(op_t op, logic signed [KEY_W-1:0] key,
                              logic [COLOR_W-1:0] bg, logic [COLOR_W-1:0] fg);
        table_word_t w;
        w = '{op: op, key: key, bg: bg, fg: fg};
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // Keys are drawn shortly before they are sent so that exact hits follow
    // the table as it grows.
    task automatic run_random(int count);
        int  n;
        op_t op;
        for (n = 0; n < count; n++)
        begin
            while (pending_words.size() >= 4)
                @(posedge clk);
            op = ($urandom_range(5) == 0) ? OP_INSERT : OP_LOOKUP;
            queue_word(op, pick_key(op == OP_INSERT), 24'($urandom), 24'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (words_checked != words_queued)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_DEFAULT_BG)
            dflt_bg = val;
        else if (idx == CFG_DEFAULT_FG)
            dflt_fg = val;
    endtask

    task automatic program_defaults(logic [COLOR_W-1:0] bg, logic [COLOR_W-1:0] fg,
                                    bit poke_unmapped);
        cfg_write(CFG_DEFAULT_BG, bg);
        cfg_write(CFG_DEFAULT_FG, fg);
        if (poke_unmapped)
            cfg_write(CFG_UNMAPPED, 24'h00FF00);
        cfg_valid <= 1'b0;
    endtask

    // Sender: one word offered at a time, held until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin : sender
            table_word_t w;
            if (s_tvalid && s_tready)
                expected_colors = {expected_colors,
                                   apply_table_word(op_t'(s_tuser[0]), s_tdata[63:0],
                                                    s_tdata[87:64], s_tdata[111:88])};
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {w.fg, w.bg, w.key};
                    s_tuser  <= w.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, started once on request.
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks every accepted result word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin : receiver
            color_result_t due;
            if (m_tvalid && m_tready)
            begin
                words_checked++;
                if (expected_colors.size() == 0)
                begin
                    $error("result word with no prediction waiting: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    due = expected_colors.pop_front();
                    if (m_tdata[23:0] !== due.bg)
                    begin
                        $error("bg_color expected %h, got %h", due.bg, m_tdata[23:0]);
                        mismatches++;
                    end
                    if (m_tdata[47:24] !== due.fg)
                    begin
                        $error("fg_color expected %h, got %h", due.fg, m_tdata[47:24]);
                        mismatches++;
                    end
                    if (m_tuser[0] !== due.matched)
                    begin
                        $error("matched expected %b, got %b", due.matched, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== due.full)
                    begin
                        $error("table_full expected %b, got %b", due.full, m_tuser[1]);
                        mismatches++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(8 * 200000);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: every lookup falls back to the reset defaults.
        queue_word(OP_LOOKUP, KEY_MIN, 24'hFFFFFF, 24'hFFFFFF);
        queue_word(OP_LOOKUP, KEY_MAX, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, 64'sd0, 24'h5A5A5A, 24'hA5A5A5);
        queue_word(OP_INSERT, 64'sd0, 24'hFFFFFF, 24'h000000);
        queue_word(OP_INSERT, -64'sd100, 24'h000000, 24'hFFFFFF);
        // A second entry at the same minimum goes in front of the first.
        queue_word(OP_INSERT, 64'sd0, 24'hA5A5A5, 24'h5A5A5A);
        queue_word(OP_INSERT, KEY_MAX, 24'h123456, 24'h654321);
        queue_word(OP_INSERT, KEY_MIN + 64'sd1, 24'h0F0F0F, 24'hF0F0F0);
        queue_word(OP_LOOKUP, 64'sd0, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, 64'sd5, 24'hFFFFFF, 24'hFFFFFF);
        queue_word(OP_LOOKUP, -64'sd100, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, -64'sd99, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, -64'sd101, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, KEY_MIN, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, KEY_MIN + 64'sd1, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, KEY_MAX, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, KEY_MAX - 64'sd1, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, -64'sd1, 24'h000000, 24'h000000);
        queue_word(OP_INSERT, -64'sd100, 24'h3C3C3C, 24'hC3C3C3);
        queue_word(OP_LOOKUP, -64'sd50, 24'h000000, 24'h000000);
        queue_word(OP_LOOKUP, -64'sd100, 24'h000000, 24'h000000);
        wait_drained();

        // The table fills during the random phases; later inserts are dropped.
        program_defaults(24'h000000, 24'h000000, 1'b1);
        run_random(95);
        wait_drained();

        program_defaults(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_idle_pct = 48;
        run_random(95);
        wait_drained();

        program_defaults(24'($urandom), 24'($urandom), 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 48;
        hold_go = 1'b1;
        run_random(95);
        wait_drained();

        program_defaults(24'($urandom), 24'($urandom), 1'b0);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        run_random(95);
        wait_drained();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
